/* rtl/svt_pkg.sv */
// ----------------------------------------------------------------------------
// svt_pkg
// Types, sizes and codes shared by the sorted value table modules.
// ----------------------------------------------------------------------------
package svt_pkg;

    localparam int DEPTH      = 16;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // operation codes
    localparam logic [1:0] FUNC_INSERT     = 2'd0;
    localparam logic [1:0] FUNC_REMOVE_POS = 2'd1;
    localparam logic [1:0] FUNC_REMOVE_VAL = 2'd2;

    // status codes
    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_FULL    = 2'd1;
    localparam logic [1:0] ST_BAD_POS = 2'd2;

    typedef struct packed {
        logic [1:0]                   func;
        logic signed [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]             position;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]       status;
        logic [CNT_W-1:0] fill_count;
        logic [CNT_W-1:0] removed_count;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INSERT,
        S_REMOVE_POS,
        S_REMOVE_VAL,
        S_DONE
    } t_state;

    typedef struct packed {
        logic                         en;
        logic [IDX_W-1:0]             addr;
        logic signed [VALUE_BITS-1:0] data;
    } t_wr_req;

    typedef struct packed {
        logic gt;
        logic eq;
    } t_cmp_res;

endpackage

/* rtl/sorted_value_table.sv */
// ----------------------------------------------------------------------------
// sorted_value_table
// Bounded table of signed values held in ascending order.
// ----------------------------------------------------------------------------
// The table holds up to DEPTH (16) signed values in ascending order and takes
// one operation per input beat: insert (after any equal copies), remove the
// entry at a zero-based position, or remove every copy of a value. Each beat
// returns one result beat with a status, the fill count after the operation
// and how many entries were removed. One sequencer walks the entry register
// file one entry per cycle through a single shared compare unit, and the input
// is stalled until the result register has been loaded. An insert shifts
// entries up from the top until the slot is found, a remove at position
// pulls the entries above it down, and a remove of a value walks the whole
// fill and compacts the survivors; the beat is accepted in idle and the
// result register is loaded after the walk. A rejected beat (full table,
// position past the end, unused operation code) goes from idle straight to
// loading the result. The result register lets the next beat be accepted
// while the previous result still waits downstream. There is no clearing
// pass after reset.
// ----------------------------------------------------------------------------
module sorted_value_table import svt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    t_state                       r_state, n_state;
    logic [1:0]                   r_func;
    logic signed [VALUE_BITS-1:0] r_value;
    logic [CNT_W-1:0]             r_rd, n_rd;
    logic [CNT_W-1:0]             r_wr, n_wr;
    logic [CNT_W-1:0]             r_occ, n_occ;
    logic [CNT_W-1:0]             r_removed, n_removed;
    logic [1:0]                   r_status, n_status;
    logic                         r_out_valid;
    t_out_beat                    r_out;

    logic                         in_fire;
    logic                         out_load;
    logic [CNT_W-1:0]             wr_plus1;
    logic [CNT_W-1:0]             wr_minus1;
    logic [IDX_W-1:0]             rd_addr;
    logic signed [VALUE_BITS-1:0] rd_data;
    t_wr_req                      wr_req;
    t_cmp_res                     cmp;

    assign in_fire   = i_in_valid && !o_in_stall;
    assign out_load  = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign wr_plus1  = r_wr + CNT_W'(1);
    assign wr_minus1 = r_wr - CNT_W'(1);

    svt_store u_store (
        .i_clk     (i_clk),
        .i_wr      (wr_req),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    svt_cmp u_cmp (
        .i_a   (rd_data),
        .i_b   (r_value),
        .o_res (cmp)
    );

    // Next state: accept in idle, walk the table, wait in done until the result register is free.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_in_data.func)
                        FUNC_INSERT: begin
                            n_state = (r_occ >= CNT_W'(DEPTH)) ? S_DONE : S_INSERT;
                        end
                        FUNC_REMOVE_POS: begin
                            n_state = ({1'b0, i_in_data.position} >= r_occ)
                                      ? S_DONE : S_REMOVE_POS;
                        end
                        FUNC_REMOVE_VAL: n_state = S_REMOVE_VAL;
                        default:         n_state = S_DONE;
                    endcase
                end
            end
            S_INSERT: begin
                if ((r_wr == '0) || !cmp.gt) begin
                    n_state = S_DONE;
                end
            end
            S_REMOVE_POS: begin
                if (wr_plus1 >= r_occ) begin
                    n_state = S_DONE;
                end
            end
            S_REMOVE_VAL: begin
                if (r_rd == r_occ) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath control: read address, write request and counter updates.
    always_comb begin
        n_rd       = r_rd;
        n_wr       = r_wr;
        n_occ      = r_occ;
        n_removed  = r_removed;
        n_status   = r_status;
        rd_addr    = r_rd[IDX_W-1:0];
        wr_req.en   = 1'b0;
        wr_req.addr = r_wr[IDX_W-1:0];
        wr_req.data = r_value;
        case (r_state)
            S_IDLE: begin
                n_rd      = '0;
                n_removed = '0;
                n_status  = ST_DONE;
                case (i_in_data.func)
                    FUNC_INSERT: begin
                        n_wr = r_occ;
                        if (r_occ >= CNT_W'(DEPTH)) begin
                            n_status = ST_FULL;
                        end
                    end
                    FUNC_REMOVE_POS: begin
                        n_wr = {1'b0, i_in_data.position};
                        if ({1'b0, i_in_data.position} >= r_occ) begin
                            n_status = ST_BAD_POS;
                        end
                    end
                    default: n_wr = '0;
                endcase
            end
            S_INSERT: begin
                // shift larger entries up one slot, drop the value in below them
                rd_addr   = wr_minus1[IDX_W-1:0];
                wr_req.en = 1'b1;
                if ((r_wr != '0) && cmp.gt) begin
                    wr_req.data = rd_data;
                    n_wr        = wr_minus1;
                end else begin
                    n_occ = r_occ + CNT_W'(1);
                end
            end
            S_REMOVE_POS: begin
                // pull entries above the hole down one slot
                rd_addr = wr_plus1[IDX_W-1:0];
                if (wr_plus1 >= r_occ) begin
                    n_occ     = r_occ - CNT_W'(1);
                    n_removed = CNT_W'(1);
                end else begin
                    wr_req.en   = 1'b1;
                    wr_req.data = rd_data;
                    n_wr        = wr_plus1;
                end
            end
            S_REMOVE_VAL: begin
                // compact: keep non-matching entries, count matches
                if (r_rd == r_occ) begin
                    n_occ = r_wr;
                end else begin
                    n_rd = r_rd + CNT_W'(1);
                    if (cmp.eq) begin
                        n_removed = r_removed + CNT_W'(1);
                    end else begin
                        wr_req.en   = 1'b1;
                        wr_req.data = rd_data;
                        n_wr        = wr_plus1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_occ   <= n_occ;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers: no reset
    always_ff @(posedge i_clk) begin
        r_rd      <= n_rd;
        r_wr      <= n_wr;
        r_removed <= n_removed;
        r_status  <= n_status;
        if (in_fire) begin
            r_func  <= i_in_data.func;
            r_value <= i_in_data.value;
        end
        if (out_load) begin
            r_out.status        <= r_status;
            r_out.fill_count    <= r_occ;
            r_out.removed_count <= (r_func == FUNC_REMOVE_POS || r_func == FUNC_REMOVE_VAL)
                                   ? r_removed : '0;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= CNT_W'(DEPTH))
        else $error("fill count beyond table depth");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> (r_state != S_IDLE))
        else $error("accepted beat did not start an operation");

    a_full_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && r_status == ST_FULL) |-> (r_occ == CNT_W'(DEPTH)))
        else $error("full status reported on a table with room");

    a_compact_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE_VAL) |-> (r_wr <= r_rd && r_rd <= r_occ))
        else $error("compaction pointers out of order");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_REMOVE_POS && n_state == S_DONE)
        |=> (r_occ == $past(r_occ) - CNT_W'(1)))
        else $error("remove at position did not shrink the table");

endmodule

/* rtl/svt_cmp.sv */
// ----------------------------------------------------------------------------
// svt_cmp
// Shared compare unit: signed greater-than and equality of two signed values.
// ----------------------------------------------------------------------------
module svt_cmp import svt_pkg::*; (
    input  logic signed [VALUE_BITS-1:0] i_a,
    input  logic signed [VALUE_BITS-1:0] i_b,
    output t_cmp_res                     o_res
);

    assign o_res.gt = (i_a > i_b);
    assign o_res.eq = (i_a == i_b);

endmodule

/* rtl/svt_store.sv */
// ----------------------------------------------------------------------------
// svt_store
// Entry register file: one write and one read address per cycle.
// ----------------------------------------------------------------------------
module svt_store import svt_pkg::*; (
    input  logic                         i_clk,
    input  t_wr_req                      i_wr,
    input  logic [IDX_W-1:0]             i_rd_addr,
    output logic signed [VALUE_BITS-1:0] o_rd_data
);

    // no reset: entries past the fill count are never used
    logic signed [VALUE_BITS-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd_data = r_mem[i_rd_addr];

endmodule

/* test/tb_sorted_value_table.sv */
// ----------------------------------------------------------------------------
// tb_sorted_value_table
// Self-checking testbench for the sorted value table.
// ----------------------------------------------------------------------------
// Drives table operations into the block over the input valid/stall channel.
// A predictor keeps its own copy of the sorted entries and the fill count and
// works out the result of every accepted beat. A checker compares each result
// beat field by field with the oldest prediction. Directed tests cover the
// empty table, ordering with duplicates at the head and tail, and a full
// table. Random traffic with varying insert bias follows. Both sides idle in
// short random bursts. One test holds the receiver off for a long stretch.
// ----------------------------------------------------------------------------
module tb_sorted_value_table;
    import svt_pkg::*;

    // func code the block does not define; it must act as a no-op
    localparam logic [1:0] FUNC_UNUSED = 2'd3;

    localparam logic signed [VALUE_BITS-1:0] VAL_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};
    localparam logic signed [VALUE_BITS-1:0] VAL_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

    // watchdog limit, set well above the length of a full run
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 300;

    logic      i_clk       = 1'b0;
    logic      i_rst_n     = 1'b0;
    logic      i_in_valid  = 1'b0;
    logic      o_in_stall;
    t_in_beat  i_in_data   = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_beat o_out_data;

    // predictor state: sorted entries and how many are valid
    logic signed [VALUE_BITS-1:0] model_entries [DEPTH];
    int                           model_fill = 0;

    // predicted result beats, oldest first
    t_out_beat pending_op_results [$];
    t_out_beat want_result;

    int  fail_count  = 0;
    int  cycle_count = 0;
    bit  in_idle_en  = 1'b1;
    bit  out_idle_en = 1'b1;

    // receiver hold-off: a test posts a request, the receiver counts it down
    int   out_hold_req   = 0;
    int   out_hold_left  = 0;
    int   out_burst_left = 0;
    logic out_stall_next;

    sorted_value_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    always #2 i_clk = ~i_clk;

    // Apply one operation to the predictor copy and return its result beat.
    function automatic t_out_beat predict_table_op(input t_in_beat beat);
        t_out_beat                    res;
        logic signed [VALUE_BITS-1:0] v;
        int                           at;
        int                           kept;
        int                           removed;
        res.status = ST_DONE;
        removed    = 0;
        v          = beat.value;
        case (beat.func)
            FUNC_INSERT: begin
                if (model_fill >= DEPTH) begin
                    res.status = ST_FULL;
                end else begin
                    // land after any equal copies already held
                    at = 0;
                    while (at < model_fill && model_entries[at] <= v)
                        at++;
                    for (int i = model_fill; i > at; i--)
                        model_entries[i] = model_entries[i-1];
                    model_entries[at] = v;
                    model_fill++;
                end
            end
            FUNC_REMOVE_POS: begin
                if (beat.position >= model_fill) begin
                    res.status = ST_BAD_POS;
                end else begin
                    for (int i = beat.position; i + 1 < model_fill; i++)
                        model_entries[i] = model_entries[i+1];
                    model_fill--;
                    removed = 1;
                end
            end
            FUNC_REMOVE_VAL: begin
                // compact the survivors toward the head
                kept = 0;
                for (int i = 0; i < model_fill; i++) begin
                    if (model_entries[i] == v)
                        removed++;
                    else
                        model_entries[kept++] = model_entries[i];
                end
                model_fill = kept;
            end
            default: ;
        endcase
        res.fill_count    = CNT_W'(model_fill);
        res.removed_count = CNT_W'(removed);
        return res;
    endfunction

    // Offer one beat, hold it until accepted, then record its prediction.
    task automatic send_op(input logic [1:0] func,
                           input logic signed [VALUE_BITS-1:0] value,
                           input logic [IDX_W-1:0] position);
        t_in_beat beat;
        int       gap;
        beat.func     = func;
        beat.value    = value;
        beat.position = position;
        gap = 0;
        if (in_idle_en && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= beat;
        do @(posedge i_clk); while (o_in_stall);
        pending_op_results.push_back(predict_table_op(beat));
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic wait_drain();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_op_results.size() != 0);
    endtask

    // Random operations. Most removes aim at entries that are present and
    // positions inside the fill, so the table keeps reaching deep states.
    task automatic run_random_ops(input int n_ops, input int insert_pct);
        logic [1:0]                   func;
        logic signed [VALUE_BITS-1:0] value;
        logic [IDX_W-1:0]             position;
        int                           roll;
        for (int n = 0; n < n_ops; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < 2)
                func = FUNC_UNUSED;
            else if (roll < 2 + insert_pct)
                func = FUNC_INSERT;
            else if (roll < 2 + insert_pct + (98 - insert_pct) / 2)
                func = FUNC_REMOVE_POS;
            else
                func = FUNC_REMOVE_VAL;

            // small pool for duplicates, a few extremes, the rest full range
            roll = $urandom_range(0, 99);
            if (roll < 55) begin
                value = $urandom_range(0, 6) - 3;
            end else if (roll < 70) begin
                case ($urandom_range(0, 3))
                    0:       value = VAL_MIN;
                    1:       value = VAL_MAX;
                    2:       value = VAL_MIN + 1;
                    default: value = VAL_MAX - 1;
                endcase
            end else begin
                value = $urandom;
            end
            if (func == FUNC_REMOVE_VAL && model_fill > 0 && $urandom_range(0, 9) < 7)
                value = model_entries[$urandom_range(0, model_fill - 1)];

            if (model_fill > 0 && $urandom_range(0, 9) < 8)
                position = IDX_W'($urandom_range(0, model_fill - 1));
            else
                position = IDX_W'($urandom_range(0, DEPTH - 1));

            send_op(func, value, position);
        end
    endtask

    // Empty table: no-op code, position past end, absent value.
    task automatic test_empty_table();
        send_op(FUNC_UNUSED, VAL_MAX, 4'd0);
        send_op(FUNC_REMOVE_POS, 32'sd0, 4'd0);
        send_op(FUNC_REMOVE_POS, VAL_MIN, 4'd15);
        send_op(FUNC_REMOVE_VAL, VAL_MIN, 4'd0);
    endtask

    // Extremes and duplicates at head and tail, then remove them all.
    task automatic test_ordering();
        send_op(FUNC_INSERT, VAL_MAX, 4'd15);
        send_op(FUNC_INSERT, VAL_MIN, 4'd0);
        send_op(FUNC_INSERT, VAL_MIN, 4'd0);
        send_op(FUNC_INSERT, -32'sd1, 4'd0);
        send_op(FUNC_INSERT, VAL_MAX, 4'd0);
        send_op(FUNC_REMOVE_VAL, VAL_MIN, 4'd0);
        send_op(FUNC_REMOVE_VAL, VAL_MAX, 4'd0);
        send_op(FUNC_REMOVE_VAL, 32'sd12345, 4'd0);
        send_op(FUNC_UNUSED, 32'sd0, 4'd15);
        send_op(FUNC_REMOVE_POS, -32'sd1, 4'd1);
        send_op(FUNC_REMOVE_POS, -32'sd1, 4'd0);
        wait_drain();
    endtask

    // Fill to the top, reject one more, remove last slot, clear the rest.
    task automatic test_full_table();
        for (int i = 0; i < DEPTH; i++)
            send_op(FUNC_INSERT, (i % 2) ? 32'sd0 : -32'sd2, 4'd0);
        send_op(FUNC_INSERT, 32'sd7, 4'd0);
        send_op(FUNC_REMOVE_POS, 32'sd0, 4'd15);
        send_op(FUNC_REMOVE_POS, 32'sd0, 4'd15);
        send_op(FUNC_REMOVE_VAL, -32'sd2, 4'd0);
        send_op(FUNC_REMOVE_VAL, 32'sd0, 4'd0);
        wait_drain();
    endtask

    task automatic test_random_mix();
        run_random_ops(500, 55);
        run_random_ops(500, 70);
        run_random_ops(400, 35);
    endtask

    // Hold the receiver off long enough for the block to stall its input,
    // keep offering beats meanwhile, then pause until all results are in.
    task automatic test_backpressure();
        out_hold_req = HOLD_CYCLES;
        run_random_ops(24, 60);
        wait_drain();
    endtask

    // Last stretch runs back to back on both sides.
    task automatic test_streaming();
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        run_random_ops(330, 50);
    endtask

    // Receiver: long hold when asked, otherwise short random stall bursts.
    always @(posedge i_clk) begin
        out_stall_next = 1'b0;
        if (out_hold_req > 0) begin
            out_hold_left = out_hold_req;
            out_hold_req  = 0;
        end
        if (!i_rst_n) begin
            out_stall_next = 1'b0;
        end else if (out_hold_left > 0) begin
            out_hold_left--;
            out_stall_next = 1'b1;
        end else if (out_burst_left > 0) begin
            out_burst_left--;
            out_stall_next = 1'b1;
        end else if (out_idle_en && $urandom_range(0, 4) == 0) begin
            out_burst_left = $urandom_range(1, 5) - 1;
            out_stall_next = 1'b1;
        end
        i_out_stall <= out_stall_next;
    end

    // Checker: compare each accepted result beat with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall) begin
            if (pending_op_results.size() == 0) begin
                $error("result beat with no operation pending");
                fail_count++;
            end else begin
                want_result = pending_op_results.pop_front();
                if (o_out_data.status !== want_result.status) begin
                    $error("status: expected %0d, got %0d",
                           want_result.status, o_out_data.status);
                    fail_count++;
                end
                if (o_out_data.fill_count !== want_result.fill_count) begin
                    $error("fill_count: expected %0d, got %0d",
                           want_result.fill_count, o_out_data.fill_count);
                    fail_count++;
                end
                if (o_out_data.removed_count !== want_result.removed_count) begin
                    $error("removed_count: expected %0d, got %0d",
                           want_result.removed_count, o_out_data.removed_count);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_ordering();
        test_full_table();
        test_random_mix();
        test_backpressure();
        test_streaming();

        // let the last results drain and the block settle
        wait_drain();
        repeat (DEPTH + 4) @(posedge i_clk);
        if (pending_op_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_op_results.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/svt_pkg.sv
rtl/svt_cmp.sv
rtl/svt_store.sv
rtl/sorted_value_table.sv
test/tb_sorted_value_table.sv
